>>> hw/rtl/gpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpc_pkg
// shared types, constants and helpers for the gated pose composer
// ----------------------------------------------------------------------------
package gpc_pkg;

  localparam int FracBits  = 16;
  localparam int WordWidth = 32;
  localparam int OutBits   = (WordWidth > 32) ? 32 : WordWidth;
  localparam int unsigned LimReset = 32'd655360;

  typedef enum logic [1:0] {
    ST_APPLIED  = 2'd0,
    ST_NORM     = 2'd1,
    ST_SINGULAR = 2'd2
  } status_e;

  // sequencer states of the composer
  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_COF, S_DET, S_GATE, S_DIV, S_DIVW, S_U,
    S_RD, S_MAC, S_WR, S_OUTRD, S_OUTW, S_OUT
  } state_e;

  typedef struct packed {
    logic signed [31:0] rot_00;
    logic signed [31:0] rot_01;
    logic signed [31:0] rot_02;
    logic signed [31:0] rot_10;
    logic signed [31:0] rot_11;
    logic signed [31:0] rot_12;
    logic signed [31:0] rot_20;
    logic signed [31:0] rot_21;
    logic signed [31:0] rot_22;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         row_index;
    logic signed [31:0] col_a;
    logic signed [31:0] col_b;
    logic signed [31:0] col_c;
    logic signed [31:0] col_d;
    logic               last;
  } out_word_t;

  // saturate a wide signed value to the word range
  function automatic logic signed [31:0] sat32(input logic signed [95:0] x);
    logic signed [95:0] hi;
    logic signed [95:0] lo;
    hi = (96'sd1 <<< (OutBits - 1)) - 96'sd1;
    lo = -hi - 96'sd1;
    if (x > hi) sat32 = hi[31:0];
    else if (x < lo) sat32 = lo[31:0];
    else sat32 = x[31:0];
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/gpc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpc_div
// restoring divider, one quotient bit per cycle, truncating, saturated result
// ----------------------------------------------------------------------------
module gpc_div (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_i,
  input  wire signed [31:0]    num_i,
  input  wire signed [31:0]    den_i,
  output logic                 done_o,
  output logic signed [31:0]   quo_o
);
  import gpc_pkg::*;

  // numerator is num << FracBits, up to 48 bits magnitude
  localparam int NW = 32 + FracBits;

  logic [NW-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [31:0]   den_q, den_d;
  logic          neg_q, neg_d, busy_q, busy_d;
  logic [5:0]    cnt_q, cnt_d;
  logic [NW:0]   trial;
  logic signed [95:0] sq;
  logic [NW-1:0] nmag;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; neg_d = neg_q;
    busy_d = busy_q; cnt_d = cnt_q; done_o = 1'b0;
    nmag = num_i[31] ? NW'(-{{FracBits{num_i[31]}}, num_i}) << FracBits
                     : NW'({{FracBits{1'b0}}, num_i}) << FracBits;
    trial = {rem_q[NW-2:0], quo_q[NW-1]} - {1'b0, {(NW-32){1'b0}}, den_q};
    if (start_i) begin
      rem_d = '0; quo_d = nmag;
      den_d = den_i[31] ? 32'(-den_i) : den_i;
      neg_d = num_i[31] ^ den_i[31];
      busy_d = 1'b1; cnt_d = 6'(NW);
    end else if (busy_q) begin
      // shift one numerator bit in, subtract if it fits
      if (!trial[NW]) begin
        rem_d = trial[NW-1:0];
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[NW-2:0], quo_q[NW-1]};
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_o = 1'b1;
      end
    end
    sq = neg_q ? -$signed({48'd0, quo_d}) : $signed({48'd0, quo_d});
    quo_o = sat32(sq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; neg_q <= neg_d;
  end

endmodule
`default_nettype wire

>>> hw/rtl/gated_pose_compose.sv
`default_nettype none
// When the motion is applied, the transposed cofactors go through nine serial
// divisions by the determinant before the first row; a rejected motion skips them.
// One motion at a time: input is taken only in idle, after the last row of the
// previous motion has left; output stalls hold the sequencer.
// Reset loads an identity pose (input stalled) and the limit 10.0.
// ----------------------------------------------------------------------------
// gated_pose_compose
// composes the stored pose with the inverse of each gated motion
// ----------------------------------------------------------------------------
module gated_pose_compose (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  gpc_pkg::in_word_t     in_data_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output gpc_pkg::out_word_t    out_data_o,
  input  wire                   cfg_we_i,
  input  wire [30:0]            cfg_data_i
);
  import gpc_pkg::*;

  state_e state_q, state_d;

  // pose memory, 12 words, one read one write per cycle
  logic signed [31:0] mem [12];
  logic [3:0]         ra, wa;
  logic               we;
  logic signed [31:0] wd, rd_q;
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  // item storage
  logic signed [31:0] r_q [9];
  logic signed [31:0] t_q [3];
  logic signed [31:0] cof_q [9];
  logic signed [31:0] inv_q [9];
  logic signed [31:0] u_q [3];
  logic signed [31:0] np_q [12];
  logic signed [31:0] det_q;
  logic [1:0]         stat_q, stat_d;
  logic [30:0]        lim_q;
  logic [3:0]         idx_q, idx_d;
  logic [1:0]         k_q, k_d;
  logic signed [95:0] acc_q, acc_d;
  logic [1:0]         row_q, row_d;
  logic signed [31:0] pk_q [4];

  // shared multiplier, floor shift
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [63:0] fm;
  assign prod = ma * mb;
  assign fm   = prod >>> FracBits;

  // divider
  logic               dstart, ddone;
  logic signed [31:0] dnum, dquo;
  gpc_div u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(det_q),
    .done_o(ddone), .quo_o(dquo)
  );

  // cofactor index helpers
  function automatic logic [3:0] ri(input logic [1:0] i, input logic [1:0] j);
    ri = 4'(i) * 4'd3 + 4'(j);
  endfunction
  function automatic logic [1:0] nx(input logic [1:0] i, input logic [1:0] d);
    logic [2:0] s;
    s = 3'(i) + 3'(d);
    nx = (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
  endfunction
  // flat index 0..8 to {row, column}
  function automatic logic [3:0] rc(input logic [3:0] n);
    case (n)
      4'd0:    rc = {2'd0, 2'd0};
      4'd1:    rc = {2'd0, 2'd1};
      4'd2:    rc = {2'd0, 2'd2};
      4'd3:    rc = {2'd1, 2'd0};
      4'd4:    rc = {2'd1, 2'd1};
      4'd5:    rc = {2'd1, 2'd2};
      4'd6:    rc = {2'd2, 2'd0};
      4'd7:    rc = {2'd2, 2'd1};
      4'd8:    rc = {2'd2, 2'd2};
      default: rc = 4'd0;
    endcase
  endfunction

  logic [1:0] ci, cj;
  logic signed [63:0] nsq;
  logic [63:0] lsq;
  assign nsq = (t_q[0] * t_q[0]) + (t_q[1] * t_q[1]);
  // third square comes from the shared multiplier in the gate state

  always_comb begin
    state_d = state_q; idx_d = idx_q; k_d = k_q; acc_d = acc_q;
    stat_d = stat_q; row_d = row_q;
    ma = '0; mb = '0; we = 1'b0; wa = idx_q; wd = '0; ra = '0;
    dstart = 1'b0; dnum = '0; in_stall_o = 1'b1; out_valid_o = 1'b0;
    {ci, cj} = rc(idx_q);
    lsq = {33'd0, lim_q} * {33'd0, lim_q};
    case (state_q)
      S_INIT: begin
        // identity load
        we = 1'b1; wa = idx_q;
        wd = (idx_q == 4'd0 || idx_q == 4'd5 || idx_q == 4'd10)
             ? sat32(96'sd1 <<< FracBits) : '0;
        idx_d = idx_q + 4'd1;
        if (idx_q == 4'd11) begin idx_d = '0; state_d = S_IDLE; end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          idx_d = '0; k_d = '0; acc_d = '0; row_d = '0; state_d = S_COF;
        end
      end
      S_COF: begin
        // two products per cofactor, k selects which
        if (k_q == 2'd0) begin
          ma = r_q[ri(nx(ci, 2'd1), nx(cj, 2'd1))];
          mb = r_q[ri(nx(ci, 2'd2), nx(cj, 2'd2))];
          acc_d = 96'(fm); k_d = 2'd1;
        end else begin
          ma = r_q[ri(nx(ci, 2'd1), nx(cj, 2'd2))];
          mb = r_q[ri(nx(ci, 2'd2), nx(cj, 2'd1))];
          k_d = 2'd0; acc_d = '0;
          idx_d = idx_q + 4'd1;
          if (idx_q == 4'd8) begin idx_d = '0; state_d = S_DET; end
        end
      end
      S_DET: begin
        ma = r_q[4'(idx_q)]; mb = cof_q[4'(idx_q)];
        acc_d = acc_q + 96'(fm);
        idx_d = idx_q + 4'd1;
        if (idx_q == 4'd2) begin idx_d = '0; state_d = S_GATE; end
      end
      S_GATE: begin
        ma = t_q[2]; mb = t_q[2];
        if ($unsigned(nsq) + $unsigned(prod) >= lsq) begin
          stat_d = ST_NORM; state_d = S_OUTRD; row_d = '0; idx_d = '0;
        end else if (det_q == '0) begin
          stat_d = ST_SINGULAR; state_d = S_OUTRD; row_d = '0; idx_d = '0;
        end else begin
          stat_d = ST_APPLIED; state_d = S_DIV; idx_d = '0;
        end
      end
      S_DIV: begin
        // inv[i][j] = cof[j][i] / det
        dstart = 1'b1; dnum = cof_q[ri(cj, ci)]; state_d = S_DIVW;
      end
      S_DIVW: begin
        if (ddone) begin
          idx_d = idx_q + 4'd1; state_d = S_DIV;
          if (idx_q == 4'd8) begin
            idx_d = '0; k_d = '0; acc_d = '0; state_d = S_U;
          end
        end
      end
      S_U: begin
        ma = inv_q[ri(idx_q[1:0], k_q)]; mb = t_q[k_q];
        acc_d = acc_q + 96'(fm); k_d = k_q + 2'd1;
        if (k_q == 2'd2) begin
          k_d = '0; acc_d = '0; idx_d = idx_q + 4'd1;
          if (idx_q == 4'd2) begin idx_d = '0; state_d = S_RD; end
        end
      end
      S_RD: begin
        // fetch pose row words 0..3 into pk
        ra = {row_q, 2'b00} + 4'(k_q);
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) begin k_d = '0; idx_d = '0; acc_d = '0; state_d = S_MAC; end
      end
      S_MAC: begin
        // idx = column 0..3, k = inner index
        ma = pk_q[k_q];
        mb = (idx_q == 4'd3) ? u_q[k_q] : inv_q[ri(k_q, idx_q[1:0])];
        acc_d = acc_q + 96'(fm);
        if (k_q == 2'd2) begin
          k_d = '0; acc_d = '0; idx_d = idx_q + 4'd1;
          if (idx_q == 4'd3) begin
            idx_d = '0; row_d = row_q + 2'd1;
            state_d = (row_q == 2'd2) ? S_WR : S_RD;
          end
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      S_WR: begin
        we = 1'b1; wa = idx_q; wd = np_q[idx_q];
        idx_d = idx_q + 4'd1;
        if (idx_q == 4'd11) begin idx_d = '0; row_d = '0; k_d = '0; state_d = S_OUTRD; end
      end
      S_OUTRD: begin
        ra = {row_q, 2'b00} + 4'(k_q);
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) begin k_d = '0; state_d = S_OUTW; end
      end
      S_OUTW: begin
        // last row word lands in pk
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          row_d = row_q + 2'd1;
          state_d = (row_q == 2'd2) ? S_IDLE : S_OUTRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // lagging capture of memory reads
  logic       cap_q;
  logic [1:0] capk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT; idx_q <= '0; k_q <= '0; row_q <= '0;
      lim_q <= 31'(LimReset); stat_q <= '0; cap_q <= 1'b0;
    end else begin
      state_q <= state_d; idx_q <= idx_d; k_q <= k_d; row_q <= row_d;
      stat_q <= stat_d;
      cap_q <= (state_q == S_RD || state_q == S_OUTRD);
      if (cfg_we_i) lim_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; capk_q <= k_q;
    if (cap_q) pk_q[capk_q] <= rd_q;
    if (state_q == S_IDLE && in_valid_i) begin
      r_q[0] <= in_data_i.rot_00; r_q[1] <= in_data_i.rot_01; r_q[2] <= in_data_i.rot_02;
      r_q[3] <= in_data_i.rot_10; r_q[4] <= in_data_i.rot_11; r_q[5] <= in_data_i.rot_12;
      r_q[6] <= in_data_i.rot_20; r_q[7] <= in_data_i.rot_21; r_q[8] <= in_data_i.rot_22;
      t_q[0] <= in_data_i.trans_x; t_q[1] <= in_data_i.trans_y;
      t_q[2] <= in_data_i.trans_z;
    end
    if (state_q == S_COF && k_q == 2'd1) cof_q[idx_q] <= sat32(acc_q - 96'(fm));
    if (state_q == S_DET && idx_q == 4'd2) det_q <= sat32(acc_q + 96'(fm));
    if (state_q == S_DIVW && ddone) inv_q[idx_q] <= dquo;
    if (state_q == S_U && k_q == 2'd2) u_q[idx_q[1:0]] <= sat32(-(acc_q + 96'(fm)));
    if (state_q == S_MAC && k_q == 2'd2)
      np_q[{row_q, idx_q[1:0]}] <= (idx_q == 4'd3)
        ? sat32(acc_q + 96'(fm) + 96'(pk_q[3])) : sat32(acc_q + 96'(fm));
  end

  // result word
  always_comb begin
    out_data_o.status    = stat_q;
    out_data_o.row_index = row_q;
    out_data_o.col_a     = pk_q[0];
    out_data_o.col_b     = pk_q[1];
    out_data_o.col_c     = pk_q[2];
    out_data_o.col_d     = pk_q[3];
    out_data_o.last      = (row_q == 2'd2);
  end

  // checks
  a_out_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> row_q != 2'd3) else $error("row out of range");
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken during output");
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> stat_q != 2'd3) else $error("bad status");

endmodule
`default_nettype wire
